// ===== src/i2p_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers of the infix to postfix converter
// no dependencies; imported by every module of the block except i2p_ram

package i2p_pkg;

	// operator stack geometry
	localparam int STACK_DEPTH = 32;
	localparam int PTR_W       = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	// character and limit register widths
	localparam int SYM_W = 8;
	localparam int LIM_W = 6;
	localparam int CMP_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;
	localparam logic [LIM_W-1:0] LIM_RESET = 6'd32;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// character codes
	localparam logic [SYM_W-1:0] SYM_MUL  = 8'h2A;
	localparam logic [SYM_W-1:0] SYM_DIV  = 8'h2F;
	localparam logic [SYM_W-1:0] SYM_ADD  = 8'h2B;
	localparam logic [SYM_W-1:0] SYM_SUB  = 8'h2D;
	localparam logic [SYM_W-1:0] SYM_LPAR = 8'h28;
	localparam logic [SYM_W-1:0] SYM_RPAR = 8'h29;
	localparam logic [SYM_W-1:0] SYM_LBRK = 8'h5B;
	localparam logic [SYM_W-1:0] SYM_RBRK = 8'h5D;
	localparam logic [SYM_W-1:0] SYM_LBRC = 8'h7B;
	localparam logic [SYM_W-1:0] SYM_RBRC = 8'h7D;

	// precedence levels
	localparam int RANK_W = 2;
	localparam logic [RANK_W-1:0] RANK_NONE = 2'd0;
	localparam logic [RANK_W-1:0] RANK_LOW  = 2'd1;
	localparam logic [RANK_W-1:0] RANK_HIGH = 2'd2;

	// classified command handed from front to back
	typedef enum logic [2:0] {
		CMD_PASS,
		CMD_OPEN,
		CMD_CLOSE,
		CMD_OPER,
		CMD_FLUSH
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [SYM_W-1:0] sym;
		logic [SYM_W-1:0] opener;
		logic [RANK_W-1:0] rank;
	} cmd_t;

	// precedence of a character, openers and others count as none
	function automatic logic [RANK_W-1:0] op_rank(input logic [SYM_W-1:0] ch);
		logic [RANK_W-1:0] r;
		unique case (ch)
			SYM_MUL, SYM_DIV: r = RANK_HIGH;
			SYM_ADD, SYM_SUB: r = RANK_LOW;
			default:          r = RANK_NONE;
		endcase
		return r;
	endfunction

endpackage

// ===== src/i2p_ram.sv =====
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies

module i2p_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/i2p_front.sv =====
`timescale 1ns / 1ps
// front end: classifies an incoming character into a stack command
// depends on i2p_pkg

module i2p_front import i2p_pkg::*; (
	input  logic [SYM_W-1:0] symbol,
	input  logic             end_of_expression,
	output cmd_t             cmd
);

	// sort the character into its command class
	always_comb begin
		cmd.sym    = symbol;
		cmd.opener = symbol;
		cmd.rank   = op_rank(symbol);
		cmd.kind   = CMD_PASS;
		if (end_of_expression) begin
			cmd.kind = CMD_FLUSH;
		end else begin
			unique case (symbol)
				SYM_LPAR, SYM_LBRK, SYM_LBRC: cmd.kind = CMD_OPEN;
				SYM_RPAR: begin
					cmd.kind   = CMD_CLOSE;
					cmd.opener = SYM_LPAR;
				end
				SYM_RBRK: begin
					cmd.kind   = CMD_CLOSE;
					cmd.opener = SYM_LBRK;
				end
				SYM_RBRC: begin
					cmd.kind   = CMD_CLOSE;
					cmd.opener = SYM_LBRC;
				end
				SYM_MUL, SYM_DIV, SYM_ADD, SYM_SUB: cmd.kind = CMD_OPER;
				default: cmd.kind = CMD_PASS;
			endcase
		end
	end

endmodule

// ===== src/i2p_queue.sv =====
`timescale 1ns / 1ps
// short command queue between the front end and the stack sequencer
// depends on i2p_pkg

module i2p_queue import i2p_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	cmd_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (fill_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_cmd    = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/i2p_back.sv =====
`timescale 1ns / 1ps
// back end: operator stack sequencer, limit register and result register
// depends on i2p_pkg and i2p_ram

module i2p_back import i2p_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [LIM_W-1:0] cfg_data,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  cmd_t             cmd,
	output logic             result_valid,
	input  logic             result_ready,
	output logic [SYM_W-1:0] out_symbol,
	output logic             last_of_run,
	output logic             overflow_seen
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SC_RD,
		ST_SC_CK,
		ST_EM_RD,
		ST_EM_WR,
		ST_FIN
	} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [LIM_W-1:0]  limit_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  j_q;
	logic [CNT_W-1:0]  k_q;
	logic              drop_q;
	logic              shown_q;
	logic              flag_q;
	logic              res_valid_q;
	logic [SYM_W-1:0]  res_sym_q;
	logic              res_last_q;
	logic              res_ovf_q;

	logic [CMP_W-1:0]  lim_ext;
	logic [CNT_W-1:0]  eff_lim;
	logic              slot_free;
	logic              take;
	logic              push_now;
	logic              full;
	logic              ram_we;
	logic [SYM_W-1:0]  push_sym;
	logic [CNT_W-1:0]  rd_cnt;
	logic [PTR_W-1:0]  rd_addr;
	logic [SYM_W-1:0]  ram_rdata;
	logic [CNT_W-1:0]  j_inc;
	logic              scan_done;
	logic [CNT_W-1:0]  scan_k;
	logic              scan_drop;
	logic [CNT_W-1:0]  scan_rem;
	logic              scan_ovf;

	assign cfg_ready     = 1'b1;
	assign result_valid  = res_valid_q;
	assign out_symbol    = res_sym_q;
	assign last_of_run   = res_last_q;
	assign overflow_seen = res_ovf_q;

	// effective limit: zero acts as one, clamp to the stack depth
	always_comb begin
		lim_ext = CMP_W'(limit_q);
		if (limit_q == '0) begin
			eff_lim = CNT_W'(1);
		end else if (lim_ext > CMP_W'(STACK_DEPTH)) begin
			eff_lim = CNT_W'(STACK_DEPTH);
		end else begin
			eff_lim = lim_ext[CNT_W-1:0];
		end
	end

	// command intake and push control
	assign slot_free = !res_valid_q || result_ready;
	assign take      = (state_q == ST_IDLE) && cmd_valid && ((cmd.kind != CMD_PASS) || slot_free);
	assign cmd_ready = take;
	assign full      = (count_q >= eff_lim);
	assign push_now  = (take && ((cmd.kind == CMD_OPEN) ||
		((cmd.kind == CMD_OPER) && (count_q == '0)))) ||
		((state_q == ST_FIN) && (cmd_q.kind == CMD_OPER));
	assign push_sym  = (state_q == ST_IDLE) ? cmd.sym : cmd_q.sym;
	assign ram_we    = push_now && !full;

	// read address walks down from the top during a scan
	always_comb begin
		if ((state_q == ST_EM_RD) || (state_q == ST_EM_WR)) begin
			rd_cnt = count_q - CNT_W'(1);
		end else begin
			rd_cnt = count_q - CNT_W'(1) - j_q;
		end
		rd_addr = rd_cnt[PTR_W-1:0];
	end

	i2p_ram #(
		.WIDTH (SYM_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[PTR_W-1:0]),
		.wdata (push_sym),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// scan step: how many entries to emit and whether an opener is dropped
	always_comb begin
		j_inc     = j_q + CNT_W'(1);
		scan_done = 1'b0;
		scan_k    = j_q;
		scan_drop = 1'b0;
		if (cmd_q.kind == CMD_CLOSE) begin
			if (ram_rdata == cmd_q.opener) begin
				scan_done = 1'b1;
				scan_drop = 1'b1;
			end else if (j_inc == count_q) begin
				scan_done = 1'b1;
				scan_k    = j_inc;
			end
		end else begin
			if (op_rank(ram_rdata) < cmd_q.rank) begin
				scan_done = 1'b1;
			end else if (j_inc == count_q) begin
				scan_done = 1'b1;
				scan_k    = j_inc;
			end
		end
		scan_rem = count_q - scan_k;
		scan_ovf = (cmd_q.kind == CMD_OPER) && (scan_rem >= eff_lim);
	end

	// sequencer, stack bookkeeping and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			limit_q     <= LIM_RESET;
			count_q     <= '0;
			j_q         <= '0;
			k_q         <= '0;
			drop_q      <= 1'b0;
			shown_q     <= 1'b0;
			flag_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (res_valid_q && result_ready) begin
				res_valid_q <= 1'b0;
			end
			if (push_now) begin
				if (full) begin
					flag_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						cmd_q <= cmd;
						unique case (cmd.kind)
							CMD_PASS: begin
								res_valid_q <= 1'b1;
								res_sym_q   <= cmd.sym;
								res_last_q  <= 1'b1;
								res_ovf_q   <= flag_q;
							end
							CMD_OPEN: begin
							end
							CMD_OPER, CMD_CLOSE: begin
								if (count_q != '0) begin
									j_q     <= '0;
									state_q <= ST_SC_RD;
								end
							end
							CMD_FLUSH: begin
								flag_q <= 1'b0;
								if (count_q != '0) begin
									shown_q <= flag_q;
									k_q     <= count_q;
									drop_q  <= 1'b0;
									state_q <= ST_EM_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SC_RD: begin
					state_q <= ST_SC_CK;
				end
				ST_SC_CK: begin
					if (scan_done) begin
						k_q     <= scan_k;
						drop_q  <= scan_drop;
						shown_q <= flag_q | scan_ovf;
						state_q <= (scan_k == '0) ? ST_FIN : ST_EM_RD;
					end else begin
						j_q     <= j_inc;
						state_q <= ST_SC_RD;
					end
				end
				ST_EM_RD: begin
					state_q <= ST_EM_WR;
				end
				ST_EM_WR: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						res_sym_q   <= ram_rdata;
						res_last_q  <= (k_q == CNT_W'(1));
						res_ovf_q   <= shown_q;
						count_q     <= count_q - CNT_W'(1);
						k_q         <= k_q - CNT_W'(1);
						state_q     <= (k_q == CNT_W'(1)) ? ST_FIN : ST_EM_RD;
					end
				end
				ST_FIN: begin
					if (drop_q) begin
						count_q <= count_q - CNT_W'(1);
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// the stack never holds more than its depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

	// a scan never reaches below the bottom of the stack
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SC_RD) || (state_q == ST_SC_CK)) |-> (j_q < count_q))
		else $error("scan index beyond stack count");

	// emitting always has at least one entry left to pop
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EM_WR) |-> (k_q != '0))
		else $error("emit with nothing left");

	// the last result of a flush leaves the stack empty
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EM_WR) && slot_free && (k_q == CNT_W'(1)) &&
		(cmd_q.kind == CMD_FLUSH)) |=> (count_q == '0))
		else $error("flush left entries on the stack");

endmodule

// ===== src/infix_to_postfix_converter.sv =====
`timescale 1ns / 1ps
// top level of the infix to postfix converter (shunting yard)
// depends on i2p_pkg, i2p_front, i2p_queue and i2p_back
//
// usage:
//   item channel (item_valid/item_ready) takes one ascii character, or an
//   end_of_expression marker that flushes the operator stack top first.
//   result channel (result_valid/result_ready) gives postfix characters;
//   last_of_run marks the final result of an item, overflow_seen the sticky
//   dropped-push flag. brackets and operators may give zero results.
//   cfg channel (cfg_valid/cfg_ready, always ready) writes stack_limit;
//   write it only while no transaction is in flight.
// operation:
//   with the stack idle, a pass-through character goes through the command
//   queue and the result register to the result port. every item is taken
//   in the idle state; a closer or operator on a non-empty stack then scans
//   entries (ram read, then compare), emits entries (ram read, then result
//   write) and finishes; a flush skips the scan. the registered-read stack
//   ram gives each read its own step. a two-entry command queue lets new
//   items enter while the stack works.
// reset clears the stack, the overflow flag and sets stack_limit to 32.
// a stalled receiver holds the result register; the sequencer waits on it
// and the queue fills, then item_ready drops.

module infix_to_postfix_converter import i2p_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [LIM_W-1:0] cfg_data,
	input  logic             item_valid,
	output logic             item_ready,
	input  logic [SYM_W-1:0] symbol,
	input  logic             end_of_expression,
	output logic             result_valid,
	input  logic             result_ready,
	output logic [SYM_W-1:0] out_symbol,
	output logic             last_of_run,
	output logic             overflow_seen
);

	cmd_t front_cmd;
	cmd_t queue_cmd;
	logic queue_valid;
	logic queue_ready;

	// classify the incoming character
	i2p_front u_front (
		.symbol            (symbol),
		.end_of_expression (end_of_expression),
		.cmd               (front_cmd)
	);

	// decouple intake from stack work
	i2p_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (item_valid),
		.push_ready (item_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_cmd    (queue_cmd)
	);

	// operator stack and result register
	i2p_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.cmd_valid     (queue_valid),
		.cmd_ready     (queue_ready),
		.cmd           (queue_cmd),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.out_symbol    (out_symbol),
		.last_of_run   (last_of_run),
		.overflow_seen (overflow_seen)
	);

endmodule
